// ===== src/crossfade_fader_mixer_assert.svh =====
// Assertion macros for the crossfade fader mixer RTL.
// Used by cfm_deadband and crossfade_fader_mixer; expects clk_i and rst_ni in scope.
`ifndef CROSSFADE_FADER_MIXER_ASSERT_SVH
`define CROSSFADE_FADER_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFM_ASSERT_IMP(lbl, ante, cons, msg)
`define CFM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/cfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the crossfade fader mixer.
// No dependencies; imported by every module of the block.
package cfm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int TOL_W     = 11;
  localparam int MODE_W    = 2;
  localparam int LEVEL_W   = 7;
  localparam int M1_W      = 24;
  localparam int PROD_W    = FRAC_W + M1_W;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [FRAC_W-1:0]  ONE_FRAC  = FRAC_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);
  localparam logic [M1_W-1:0]    PCT_SCALE = M1_W'(100);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(205);

  // mix modes; the unused code behaves as the keyer
  localparam logic [MODE_W-1:0] MODE_BLEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADDITIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEYER    = 2'd2;

  localparam logic WIN_A = 1'b0;
  localparam logic WIN_B = 1'b1;

  typedef enum logic [1:0] {
    REG_MIX_MODE,
    REG_XFADE_TOL,
    REG_FADEUP_TOL
  } reg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0] mix_mode;
    logic [TOL_W-1:0]  xfade_tol;
    logic [TOL_W-1:0]  fadeup_tol;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [TOL_W-1:0] tol;
  } db_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } db_rsp_t;

endpackage

// ===== src/cfm_regs.sv =====
`timescale 1ns / 1ps
// APB register file: mix mode and the two dead-band tolerances.
// Depends on cfm_pkg.
module cfm_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfm_pkg::cfg_t cfg_o
);
  import cfm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix_mode   <= MODE_BLEND;
      cfg_q.xfade_tol  <= TOL_RESET;
      cfg_q.fadeup_tol <= TOL_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIX_MODE:   cfg_q.mix_mode   <= pwdata[MODE_W-1:0];
        REG_XFADE_TOL:  cfg_q.xfade_tol  <= pwdata[TOL_W-1:0];
        REG_FADEUP_TOL: cfg_q.fadeup_tol <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MIX_MODE:   prdata = 32'(cfg_q.mix_mode);
      REG_XFADE_TOL:  prdata = 32'(cfg_q.xfade_tol);
      REG_FADEUP_TOL: prdata = 32'(cfg_q.fadeup_tol);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== src/cfm_deadband.sv =====
`timescale 1ns / 1ps
// Dead band and rescale of one converter count to a 17-bit fraction.
// Restoring divider, one quotient bit per cycle. Depends on cfm_pkg.
`include "crossfade_fader_mixer_assert.svh"
module cfm_deadband #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfm_pkg::db_req_t       req_i,
  input  logic [SAMPLE_BITS:0]   count_i,
  output cfm_pkg::db_rsp_t       rsp_o
);
  import cfm_pkg::*;

  localparam int VW = ((SAMPLE_BITS + 1 > TOL_W) ? SAMPLE_BITS + 1 : TOL_W) + 1;
  localparam logic [VW-1:0] FULL = VW'(2 ** SAMPLE_BITS);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_DIV} db_state_e;

  db_state_e         state_q;
  logic [VW-1:0]     c_q, tol_q, r_q, d_q;
  logic [FRAC_W-1:0] q_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;

  logic          below, above, empty, take;
  logic [VW-1:0] rem;

  // end checks of the band
  assign below = c_q < tol_q;
  assign above = (c_q + tol_q) > FULL;
  assign empty = FULL <= (tol_q << 1);

  // one compare and subtract step
  assign take = r_q >= d_q;
  assign rem  = take ? (r_q - d_q) : r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      c_q     <= '0;
      tol_q   <= '0;
      r_q     <= '0;
      d_q     <= '0;
      q_q     <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            c_q     <= VW'(count_i);
            tol_q   <= VW'(req_i.tol);
            state_q <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (below) begin
            q_q     <= '0;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (above) begin
            q_q     <= ONE_FRAC;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (empty) begin
            q_q     <= '0;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            r_q     <= c_q - tol_q;
            d_q     <= FULL - (tol_q << 1);
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= D_DIV;
          end
        end
        D_DIV: begin
          q_q <= {q_q[FRAC_W-2:0], take};
          r_q <= rem << 1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.frac = q_q;

  `CFM_ASSERT_IMP(a_db_start_idle, req_i.start, state_q == D_IDLE, "deadband started while busy")
  `CFM_ASSERT_IMP(a_db_frac_range, rsp_o.done, rsp_o.frac <= ONE_FRAC, "fraction above 1.0")
  `CFM_ASSERT_NXT(a_db_done_pulse, rsp_o.done, !rsp_o.done, "done held longer than a cycle")

endmodule

// ===== src/crossfade_fader_mixer.sv =====
`timescale 1ns / 1ps
// Top level of the crossfade fader mixer: sequencer, shared multiplier, result buffer.
// Depends on cfm_pkg, cfm_regs and cfm_deadband.
//
// Usage:
//   s_axis carries one control-surface scan per request: tdata holds the
//   crossfader and fade-to-black samples, tuser the two tap buttons.
//   m_axis carries level updates: tdata holds the level, tuser the window,
//   tlast marks the last update of a scan. A scan gives zero to two updates.
//   APB mix mode and two tolerances: user must write them only while idle, unchecked.
// Timing:
//   s_axis_tready is high only between scans. A scan runs through two passes
//   of the shared dead-band divider (check, then divide; no divide when the
//   sample is inside an end band or the band is empty; the crossfader pass
//   skipped while a tap is held), the S_MUL_FU, S_MUL_A and S_MUL_B steps of
//   the shared 17x24 multiplier and the S_DECIDE state, then one update per
//   cycle while m_axis_tready is high.
// Reset: levels clear to 0, tap history clears, registers take their defaults.
// Stall: while m_axis_tready is low the pending update holds and no new scan
//   is taken.
`include "crossfade_fader_mixer_assert.svh"
module crossfade_fader_mixer #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: crossfade_sample, fade_sample, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: tap_left, tap_right
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: fade_level, zero pad
  output logic [7:0]  m_axis_tdata,
  // tuser: window_select
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfm_pkg::*;

  localparam logic [SAMPLE_BITS:0] FULL_COUNT = (SAMPLE_BITS+1)'(2 ** SAMPLE_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DBX_GO, S_DBX_WAIT, S_DBF_GO, S_DBF_WAIT,
    S_MUL_FU, S_MUL_A, S_MUL_B, S_DECIDE, S_EMIT
  } seq_state_e;

  cfg_t    cfg;
  db_req_t db_req;
  db_rsp_t db_rsp;
  logic [SAMPLE_BITS:0] db_count;

  seq_state_e             state_q;
  logic [SAMPLE_BITS-1:0] xs_q, fs_q;
  logic [FRAC_W-1:0]      x_q, fu_q;
  logic [M1_W-1:0]        m1_q;
  logic [PROD_W-1:0]      prod_q;
  logic [LEVEL_W-1:0]     na_q, level_a_q, level_b_q;
  logic                   left_first_q;
  logic                   res_win_q [2];
  logic [LEVEL_W-1:0]     res_lvl_q [2];
  logic                   two_q, idx_q;

  logic [FRAC_W-1:0]  inv, mul_a;
  logic [M1_W-1:0]    mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic [LEVEL_W-1:0] nb;
  logic               a_chg, b_chg, a_lead, tap_l, tap_r, in_acc, out_acc;

  cfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one dead-band unit, shared by both samples
  assign db_req.start = (state_q == S_DBX_GO) || (state_q == S_DBF_GO);
  assign db_req.tol   = (state_q == S_DBX_GO) ? cfg.xfade_tol : cfg.fadeup_tol;
  assign db_count     = (state_q == S_DBX_GO) ? (FULL_COUNT - {1'b0, xs_q})
                                              : {1'b0, fs_q};

  cfm_deadband #(.SAMPLE_BITS(SAMPLE_BITS)) u_deadband (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (db_req),
    .count_i (db_count),
    .rsp_o   (db_rsp)
  );

  assign inv     = ONE_FRAC - x_q;
  assign tap_l   = s_axis_tuser[0];
  assign tap_r   = s_axis_tuser[1];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_MUL_FU: begin
        mul_a = fu_q;
        mul_b = PCT_SCALE;
      end
      S_MUL_A: begin
        mul_a = inv;
        mul_b = prod_q[M1_W-1:0];
      end
      default: begin
        mul_a = x_q;
        mul_b = m1_q;
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // new B level by mode
  always_comb begin
    if (cfg.mix_mode == MODE_BLEND && fu_q == ONE_FRAC) begin
      nb = LEVEL_MAX;
    end else if (cfg.mix_mode == MODE_BLEND || cfg.mix_mode == MODE_ADDITIVE) begin
      nb = prod_q[2*FRAC_BITS +: LEVEL_W];
    end else begin
      nb = m1_q[FRAC_BITS +: LEVEL_W];
    end
  end

  // change detection and order: higher level first
  assign a_chg  = na_q != level_a_q;
  assign b_chg  = nb != level_b_q;
  assign a_lead = a_chg && ((na_q >= nb) || !b_chg);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      xs_q         <= '0;
      fs_q         <= '0;
      x_q          <= '0;
      fu_q         <= '0;
      m1_q         <= '0;
      prod_q       <= '0;
      na_q         <= '0;
      level_a_q    <= '0;
      level_b_q    <= '0;
      left_first_q <= 1'b0;
      res_win_q[0] <= WIN_A;
      res_win_q[1] <= WIN_A;
      res_lvl_q[0] <= '0;
      res_lvl_q[1] <= '0;
      two_q        <= 1'b0;
      idx_q        <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            xs_q    <= s_axis_tdata[SAMPLE_BITS-1:0];
            fs_q    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            state_q <= S_DBF_GO;
            // taps override the crossfader; newer press wins
            if (tap_l && tap_r) begin
              x_q <= left_first_q ? ONE_FRAC : '0;
            end else if (tap_l) begin
              x_q          <= '0;
              left_first_q <= 1'b1;
            end else if (tap_r) begin
              x_q          <= ONE_FRAC;
              left_first_q <= 1'b0;
            end else begin
              state_q <= S_DBX_GO;
            end
          end
        end
        S_DBX_GO: state_q <= S_DBX_WAIT;
        S_DBX_WAIT: begin
          if (db_rsp.done) begin
            x_q     <= db_rsp.frac;
            state_q <= S_DBF_GO;
          end
        end
        S_DBF_GO: state_q <= S_DBF_WAIT;
        S_DBF_WAIT: begin
          if (db_rsp.done) begin
            fu_q    <= ONE_FRAC - db_rsp.frac;
            state_q <= S_MUL_FU;
          end
        end
        S_MUL_FU: begin
          prod_q  <= prod_d;
          state_q <= S_MUL_A;
        end
        S_MUL_A: begin
          m1_q    <= prod_q[M1_W-1:0];
          prod_q  <= prod_d;
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          na_q    <= prod_q[2*FRAC_BITS +: LEVEL_W];
          prod_q  <= prod_d;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (a_chg) level_a_q <= na_q;
          if (b_chg) level_b_q <= nb;
          if (a_chg || b_chg) begin
            res_win_q[0] <= a_lead ? WIN_A : WIN_B;
            res_lvl_q[0] <= a_lead ? na_q : nb;
            res_win_q[1] <= a_lead ? WIN_B : WIN_A;
            res_lvl_q[1] <= a_lead ? nb : na_q;
            two_q        <= a_chg && b_chg;
            idx_q        <= 1'b0;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (m_axis_tready) begin
            if (m_axis_tlast) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stream outputs
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_EMIT;
  assign m_axis_tdata  = {1'b0, res_lvl_q[idx_q]};
  assign m_axis_tuser  = res_win_q[idx_q];
  assign m_axis_tlast  = !two_q || idx_q;

  `CFM_ASSERT_IMP(a_one_scan, m_axis_tvalid, !s_axis_tready, "scan taken while updates pending")
  `CFM_ASSERT_IMP(a_level_range, m_axis_tvalid, m_axis_tdata <= 8'(LEVEL_MAX), "level above 100")
  `CFM_ASSERT_NXT(a_second_follows, out_acc && !m_axis_tlast, m_axis_tvalid, "second update lost")

endmodule
